### hw/rtl/ovn_pkg.sv
package ovn_pkg;

  // default sizing
  localparam int MAX_OCTAVES_DEF  = 8;
  localparam int COORD_FRAC_BITS  = 8;
  localparam int NOISE_FRAC_BITS  = 16;
  localparam int BASE_SCALE_SHIFT = 8;

  // hash multipliers
  localparam logic [31:0] HASH_KX    = 32'd374761393;
  localparam logic [31:0] HASH_KY    = 32'd668265263;
  localparam logic [31:0] HASH_KS    = 32'd1443059017;
  localparam logic [31:0] HASH_KO    = 32'd1274126177;
  localparam int          HASH_SHIFT = 13;

  // octave offset lattice steps
  localparam logic [31:0] OFS_XA = 32'd1297;
  localparam logic [31:0] OFS_XB = 32'd7919;
  localparam logic [31:0] OFS_YA = 32'd3571;
  localparam logic [31:0] OFS_YB = 32'd15731;

  localparam logic [18:0] NOISE_MAX = 19'h7FFFF;
  localparam logic [3:0]  OCT_RESET = 4'd4;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEED = 1'b0,
    CFG_OCT  = 1'b1
  } cfg_idx_t;

  // xor-shift step of the lattice hash
  function automatic logic [31:0] ovn_xs(input logic [31:0] g);
    ovn_xs = g ^ (g >> HASH_SHIFT);
  endfunction

  // seed-free part of the offset hash for octave i
  function automatic logic [31:0] ovn_ofs_base(input logic [31:0] i,
                                              input logic [31:0] ka,
                                              input logic [31:0] kb);
    logic [31:0] a;
    logic [31:0] b;
    a = i * ka;
    b = i * kb;
    ovn_ofs_base = a * HASH_KX + b * HASH_KY;
  endfunction

  // Q16 octave weight round(2^17 / (i*i)); lane 0 is the base layer at 1.0
  function automatic logic [17:0] ovn_lane_weight(input int i);
    case (i)
      0:       ovn_lane_weight = 18'd65536;
      1:       ovn_lane_weight = 18'd131072;
      2:       ovn_lane_weight = 18'd32768;
      3:       ovn_lane_weight = 18'd14564;
      4:       ovn_lane_weight = 18'd8192;
      5:       ovn_lane_weight = 18'd5243;
      6:       ovn_lane_weight = 18'd3641;
      7:       ovn_lane_weight = 18'd2675;
      8:       ovn_lane_weight = 18'd2048;
      9:       ovn_lane_weight = 18'd1618;
      10:      ovn_lane_weight = 18'd1311;
      11:      ovn_lane_weight = 18'd1083;
      12:      ovn_lane_weight = 18'd910;
      13:      ovn_lane_weight = 18'd776;
      14:      ovn_lane_weight = 18'd669;
      15:      ovn_lane_weight = 18'd583;
      16:      ovn_lane_weight = 18'd512;
      default: ovn_lane_weight = 18'd0;
    endcase
  endfunction

endpackage

### hw/rtl/octave_value_noise_2d.sv
// channel | direction | beat contents
// --------+-----------+-------------------------------------------
// in_     | input     | coord_x, coord_y (signed, 8 fraction bits)
// out_    | output    | noise_value (unsigned Q3.16, saturated)
// cfg_    | input     | index (0 seed, 1 octave count), 32-bit data
//
// one beat per cycle sustained while out_ready stays high; the pipeline depth is
// set by the hash and smootherstep multiplier chains of the octave lanes.
// all MAX_OCTAVES+1 lanes work in parallel, one per layer.
// rst_n is synchronous; it clears the stage valid bits and the seed, and sets the octave count to OCT_RESET.
// a stalled output holds its beat; earlier stages keep filling bubbles.
module octave_value_noise_2d #(
  parameter int MAX_OCTAVES = ovn_pkg::MAX_OCTAVES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [18:0]        out_noise_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ovn_pkg::*;

  localparam int NSTG  = 11;
  localparam int NL    = MAX_OCTAVES + 1;
  localparam int SUM_W = 18 + $clog2(NL + 1);

  // configuration registers
  logic [31:0] seed_r;
  logic [3:0]  octave_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r         <= '0;
      octave_count_r <= OCT_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SEED: seed_r         <= cfg_data;
        CFG_OCT:  octave_count_r <= cfg_data[3:0];
        default:  ;
      endcase
    end
  end

  // stage valids and enables
  logic [NSTG:1]   vld_r;
  logic [NSTG+1:1] en;

  always_comb begin
    en[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // clamped octave count
  logic [4:0] n_in;
  assign n_in = ({1'b0, octave_count_r} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
                                                             : {1'b0, octave_count_r};

  // shared stages: coordinates, count and seed term
  logic [31:0] cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r;
  logic [4:0]  n1_r, n2_r, n3_r;
  logic [31:0] sk1_r, sk2_r, sk3_r, sk4_r, sk5_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cx1_r <= in_coord_x;
      cy1_r <= in_coord_y;
      n1_r  <= n_in;
      sk1_r <= seed_r * HASH_KS;
    end
    if (en[2]) begin
      cx2_r <= cx1_r;
      cy2_r <= cy1_r;
      n2_r  <= n1_r;
      sk2_r <= sk1_r;
    end
    if (en[3]) begin
      cx3_r <= cx2_r;
      cy3_r <= cy2_r;
      n3_r  <= n2_r;
      sk3_r <= sk2_r;
    end
    if (en[4]) sk4_r <= sk3_r;
    if (en[5]) sk5_r <= sk4_r;
  end

  logic [17:0] contrib_r [NL];

  // one lane per layer; lane 0 is the base layer
  for (genvar gl = 0; gl < NL; gl++) begin : g_lane
    localparam logic [31:0] OFS_X  = ovn_ofs_base(32'(gl), OFS_XA, OFS_XB);
    localparam logic [31:0] OFS_Y  = ovn_ofs_base(32'(gl), OFS_YA, OFS_YB);
    localparam logic [17:0] LANE_W = ovn_lane_weight(gl);

    logic [31:0] gx2_r, gy2_r, hx3_r, hy3_r;
    logic [31:0] x0_4_r, y0_4_r;
    logic [15:0] tx4_r, ty4_r;
    logic        act4_r, act5_r, act6_r, act7_r, act8_r, act9_r;
    logic [31:0] mx5_r, my5_r, ttx5_r, tty5_r;
    logic [15:0] tx5_r, ty5_r;
    logic [31:0] g6_r [4];
    logic [31:0] w1x6_r, w1y6_r;
    logic [19:0] px6_r, py6_r;
    logic [15:0] cor7_r [4];
    logic [16:0] wx7_r, wy7_r, wy8_r;
    logic [15:0] r0_8_r, r1_8_r, v9_r;

    // offset hash: add and xor-shift, then final multiply
    always_ff @(posedge clk) begin
      if (en[2]) begin
        gx2_r <= ovn_xs(OFS_X + sk1_r);
        gy2_r <= ovn_xs(OFS_Y + sk1_r);
      end
      if (en[3]) begin
        hx3_r <= gx2_r * HASH_KO;
        hy3_r <= gy2_r * HASH_KO;
      end
    end

    // sample position in Q32
    logic [4:0]  sv;
    logic        act;
    logic [5:0]  sh;
    logic [63:0] ox, oy, pxn, pyn;

    always_comb begin
      if (gl == 0) begin
        sv  = 5'(BASE_SCALE_SHIFT);
        act = 1'b1;
        ox  = '0;
        oy  = '0;
      end else begin
        sv  = n3_r - 5'(gl);
        act = (5'(gl) <= n3_r);
        ox  = {{32{~hx3_r[31]}}, ~hx3_r[31], hx3_r[30:0]} << (sv + 5'd1);
        oy  = {{32{~hy3_r[31]}}, ~hy3_r[31], hy3_r[30:0]} << (sv + 5'd1);
      end
      sh  = 6'(32 - COORD_FRAC_BITS) - {1'b0, sv};
      pxn = ({{32{cx3_r[31]}}, cx3_r} << sh) + ox;
      pyn = ({{32{cy3_r[31]}}, cy3_r} << sh) + oy;
    end

    always_ff @(posedge clk) begin
      if (en[4]) begin
        x0_4_r <= pxn[63:32];
        y0_4_r <= pyn[63:32];
        tx4_r  <= pxn[31:16];
        ty4_r  <= pyn[31:16];
        act4_r <= act;
      end
    end

    // corner terms and squared fractions
    always_ff @(posedge clk) begin
      if (en[5]) begin
        mx5_r  <= x0_4_r * HASH_KX;
        my5_r  <= y0_4_r * HASH_KY;
        ttx5_r <= 32'(tx4_r) * 32'(tx4_r);
        tty5_r <= 32'(ty4_r) * 32'(ty4_r);
        tx5_r  <= tx4_r;
        ty5_r  <= ty4_r;
        act5_r <= act4_r;
      end
    end

    // corner hash sums, cubic term and the quadratic factor of the quintic polynomial
    logic [31:0] mx1, my1;
    logic [36:0] pxf, pyf;

    assign mx1 = mx5_r + HASH_KX;
    assign my1 = my5_r + HASH_KY;
    assign pxf = 37'(6) * 37'(ttx5_r) + (37'(10) << 32) - ((37'(15) * 37'(tx5_r)) << 16);
    assign pyf = 37'(6) * 37'(tty5_r) + (37'(10) << 32) - ((37'(15) * 37'(ty5_r)) << 16);

    always_ff @(posedge clk) begin
      if (en[6]) begin
        g6_r[0] <= ovn_xs(mx5_r + my5_r + sk5_r);
        g6_r[1] <= ovn_xs(mx1 + my5_r + sk5_r);
        g6_r[2] <= ovn_xs(mx5_r + my1 + sk5_r);
        g6_r[3] <= ovn_xs(mx1 + my1 + sk5_r);
        w1x6_r  <= 32'(ttx5_r[31:16]) * 32'(tx5_r);
        w1y6_r  <= 32'(tty5_r[31:16]) * 32'(ty5_r);
        px6_r   <= pxf[35:16];
        py6_r   <= pyf[35:16];
        act6_r  <= act5_r;
      end
    end

    // corner values and clamped blend weights
    logic [35:0] wxf, wyf;
    logic [31:0] hc [4];

    assign wxf = 36'(w1x6_r[31:16]) * 36'(px6_r);
    assign wyf = 36'(w1y6_r[31:16]) * 36'(py6_r);

    always_comb begin
      for (int c = 0; c < 4; c++) begin
        hc[c] = g6_r[c] * HASH_KO;
      end
    end

    always_ff @(posedge clk) begin
      if (en[7]) begin
        for (int c = 0; c < 4; c++) begin
          cor7_r[c] <= hc[c][31:16];
        end
        wx7_r  <= (wxf[35:16] > 20'd65536) ? 17'd65536 : wxf[32:16];
        wy7_r  <= (wyf[35:16] > 20'd65536) ? 17'd65536 : wyf[32:16];
        act7_r <= act6_r;
      end
    end

    // blend along x
    logic signed [16:0] d0, d1, d2;
    logic signed [34:0] m0, m1, m2;

    assign d0 = $signed({1'b0, cor7_r[1]}) - $signed({1'b0, cor7_r[0]});
    assign d1 = $signed({1'b0, cor7_r[3]}) - $signed({1'b0, cor7_r[2]});
    assign m0 = 35'(d0) * $signed({18'd0, wx7_r});
    assign m1 = 35'(d1) * $signed({18'd0, wx7_r});

    always_ff @(posedge clk) begin
      if (en[8]) begin
        r0_8_r <= cor7_r[0] + m0[31:16];
        r1_8_r <= cor7_r[2] + m1[31:16];
        wy8_r  <= wy7_r;
        act8_r <= act7_r;
      end
    end

    // blend along y
    assign d2 = $signed({1'b0, r1_8_r}) - $signed({1'b0, r0_8_r});
    assign m2 = 35'(d2) * $signed({18'd0, wy8_r});

    always_ff @(posedge clk) begin
      if (en[9]) begin
        v9_r   <= r0_8_r + m2[31:16];
        act9_r <= act8_r;
      end
    end

    // weighted contribution
    logic [33:0] wv;
    assign wv = 34'(v9_r) * 34'(LANE_W);

    always_ff @(posedge clk) begin
      if (en[10]) begin
        contrib_r[gl] <= act9_r ? wv[33:16] : '0;
      end
    end
  end

  // sum of layers and saturation
  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int l = 0; l < NL; l++) begin
      sum = sum + SUM_W'(contrib_r[l]);
    end
  end

  logic [18:0] noise_r;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      noise_r <= (sum > SUM_W'(NOISE_MAX)) ? NOISE_MAX : sum[18:0];
    end
  end

  assign out_noise_value = noise_r;

endmodule
